FILE: design/q2e_pkg.sv
package q2e_pkg;

    // Field and datapath widths
    localparam int Q_W        = 16;   // Q1.15 input components
    localparam int PROD_W     = 32;   // Q2.30 products
    localparam int SUM_W      = 34;   // doubled sums of products
    localparam int REM_W      = 62;   // square root radicand and partial root
    localparam int ROOT_W     = 31;   // root of at most 2^60
    localparam int CRD_W      = 37;   // CORDIC x/y, room for gain and pre-rotation
    localparam int ANG_W      = 32;   // internal angle, 2^32 is a full circle
    localparam int OUT_W      = 16;   // output angle width
    localparam int LANES      = 3;    // roll, pitch, yaw
    localparam int SQRT_STEPS = 31;   // one root bit per stage, radicand below 2^61
    localparam int TAB_N      = 32;   // entries of the arctangent table
    localparam int TAB_IDX_W  = $clog2(TAB_N);
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'sd1 <<< 30);
    localparam logic [REM_W-1:0] ONE_Q60 = REM_W'(64'd1 << 60);
    localparam logic [ANG_W-1:0] ANG_PI  = 32'h8000_0000;
    localparam logic [OUT_W-1:0] PITCH_POS_CLAMP = 16'h4000;
    localparam logic [OUT_W-1:0] PITCH_NEG_CLAMP = 16'hC000;

    // Values that ride alongside the radicand through the root pipeline
    typedef struct packed {
        logic signed [SUM_W-1:0] roll_s;
        logic signed [SUM_W-1:0] roll_c;
        logic signed [SUM_W-1:0] yaw_s;
        logic signed [SUM_W-1:0] yaw_c;
        logic signed [SUM_W-1:0] pitch_s;
        logic                    clamp;
        logic                    clamp_neg;
    } q2e_side_t;

    // Pitch clamp info carried through the CORDIC
    typedef struct packed {
        logic clamp;
        logic clamp_neg;
    } q2e_tag_t;

    // atan(2^-i) with 2^32 as a full circle
    function automatic logic [ANG_W-1:0] atan_tab(input logic [TAB_IDX_W-1:0] idx);
        logic [ANG_W-1:0] val;
        case (idx)
            5'd0:  val = 32'h20000000;
            5'd1:  val = 32'h12E4051E;
            5'd2:  val = 32'h09FB385B;
            5'd3:  val = 32'h051111D4;
            5'd4:  val = 32'h028B0D43;
            5'd5:  val = 32'h0145D7E1;
            5'd6:  val = 32'h00A2F61E;
            5'd7:  val = 32'h00517C55;
            5'd8:  val = 32'h0028BE53;
            5'd9:  val = 32'h00145F2F;
            5'd10: val = 32'h000A2F98;
            5'd11: val = 32'h000517CC;
            5'd12: val = 32'h00028BE6;
            5'd13: val = 32'h000145F3;
            5'd14: val = 32'h0000A2FA;
            5'd15: val = 32'h0000517D;
            5'd16: val = 32'h000028BE;
            5'd17: val = 32'h0000145F;
            5'd18: val = 32'h00000A30;
            5'd19: val = 32'h00000518;
            5'd20: val = 32'h0000028C;
            5'd21: val = 32'h00000146;
            5'd22: val = 32'h000000A3;
            5'd23: val = 32'h00000051;
            5'd24: val = 32'h00000029;
            5'd25: val = 32'h00000014;
            5'd26: val = 32'h0000000A;
            5'd27: val = 32'h00000005;
            5'd28: val = 32'h00000003;
            5'd29: val = 32'h00000001;
            5'd30: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

FILE: design/q2e_front.sv
module q2e_front
    import q2e_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [Q_W-1:0]   quat_x,
    input  logic signed [Q_W-1:0]   quat_y,
    input  logic signed [Q_W-1:0]   quat_z,
    input  logic signed [Q_W-1:0]   quat_w,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [REM_W-1:0]        out_rest,
    output q2e_side_t               out_side
);

    localparam int NS = 4;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // stage 0: products
    logic signed [PROD_W-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [PROD_W-1:0] xy_reg, zz_reg, wy_reg, zx_reg;
    // stage 1: doubled sums
    logic signed [SUM_W-1:0] rs_reg, rc_reg, ys_reg, yc_reg, ps_reg;
    // stage 2: clamp detect and square of the sine
    q2e_side_t           side2_reg;
    logic [REM_W-1:0]    sq_reg;
    // stage 3: radicand
    q2e_side_t           side3_reg;
    logic [REM_W-1:0]    rest_reg;

    logic signed [SUM_W-1:0]   rs_next, rc_next, ys_next, yc_next, ps_next;
    logic signed [ROOT_W-1:0]  ps_lo;
    logic signed [REM_W-1:0]   sq_next;
    q2e_side_t                 side2_next;

    // Advance a stage when it is empty or the one after it moves
    always_comb begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_rest  = rest_reg;
    assign out_side  = side3_reg;

    always_comb begin
        rs_next = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        ys_next = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        ps_next = (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
        rc_next = ONE_Q30 - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
        yc_next = ONE_Q30 - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);

        // square is only used when the sine is below one in magnitude
        ps_lo   = ps_reg[ROOT_W-1:0];
        sq_next = REM_W'(ps_lo) * REM_W'(ps_lo);

        side2_next.roll_s    = rs_reg;
        side2_next.roll_c    = rc_reg;
        side2_next.yaw_s     = ys_reg;
        side2_next.yaw_c     = yc_reg;
        side2_next.pitch_s   = ps_reg;
        side2_next.clamp     = (ps_reg >= ONE_Q30) || (ps_reg <= -ONE_Q30);
        side2_next.clamp_neg = ps_reg[SUM_W-1];
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            zz_reg <= quat_z * quat_z;
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
        end
        if (en[1]) begin
            rs_reg <= rs_next;
            rc_reg <= rc_next;
            ys_reg <= ys_next;
            yc_reg <= yc_next;
            ps_reg <= ps_next;
        end
        if (en[2]) begin
            side2_reg <= side2_next;
            sq_reg    <= sq_next;
        end
        if (en[3]) begin
            side3_reg <= side2_reg;
            rest_reg  <= ONE_Q60 - sq_reg;
        end
    end

endmodule

FILE: design/q2e_isqrt.sv
module q2e_isqrt
    import q2e_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REM_W-1:0]  in_rest,
    input  q2e_side_t         in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROOT_W-1:0] out_root,
    output q2e_side_t         out_side
);

    localparam int NS = SQRT_STEPS;

    logic [NS-1:0]    v_reg;
    logic [NS-1:0]    en;
    logic [REM_W-1:0] rem_reg  [NS];
    logic [REM_W-1:0] root_reg [NS];
    q2e_side_t        side_reg [NS];

    logic [REM_W-1:0] rem_next  [NS];
    logic [REM_W-1:0] root_next [NS];
    q2e_side_t        side_next [NS];

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_root  = root_reg[NS-1][ROOT_W-1:0];
    assign out_side  = side_reg[NS-1];

    // One root bit per stage, test bit walks down two places each stage
    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam logic [REM_W-1:0] BIT = REM_W'(1) << (2 * (NS - 1 - k));
        logic [REM_W-1:0] rem_src, root_src, trial;

        if (k == 0) begin : g_first
            assign rem_src    = in_rest;
            assign root_src   = '0;
            assign side_next[k] = in_side;
        end else begin : g_rest
            assign rem_src    = rem_reg[k-1];
            assign root_src   = root_reg[k-1];
            assign side_next[k] = side_reg[k-1];
        end

        assign trial = root_src + BIT;

        always_comb begin
            if (rem_src >= trial) begin
                rem_next[k]  = rem_src - trial;
                root_next[k] = (root_src >> 1) + BIT;
            end else begin
                rem_next[k]  = rem_src;
                root_next[k] = root_src >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

endmodule

FILE: design/q2e_cordic.sv
module q2e_cordic
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [CRD_W-1:0] in_x [LANES],
    input  logic signed [CRD_W-1:0] in_y [LANES],
    input  q2e_tag_t                in_tag,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ANG_W-1:0]        out_angle [LANES],
    output q2e_tag_t                out_tag
);

    // pre-rotation stage plus one stage per micro-rotation
    localparam int NS = CORDIC_STEPS + 1;

    logic [NS-1:0]           v_reg;
    logic [NS-1:0]           en;
    logic signed [CRD_W-1:0] x_reg [NS][LANES];
    logic signed [CRD_W-1:0] y_reg [NS][LANES];
    logic [ANG_W-1:0]        a_reg [NS][LANES];
    q2e_tag_t                tag_reg [NS];

    logic signed [CRD_W-1:0] x_next [NS][LANES];
    logic signed [CRD_W-1:0] y_next [NS][LANES];
    logic [ANG_W-1:0]        a_next [NS][LANES];

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_angle = a_reg[NS-1];
    assign out_tag   = tag_reg[NS-1];

    // Turn a vector with negative x by pi
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (in_x[l] < 0) begin
                x_next[0][l] = -in_x[l];
                y_next[0][l] = -in_y[l];
                a_next[0][l] = ANG_PI;
            end else begin
                x_next[0][l] = in_x[l];
                y_next[0][l] = in_y[l];
                a_next[0][l] = '0;
            end
        end
    end

    // Micro-rotations; a zero residual leaves the vector alone
    for (genvar j = 1; j < NS; j++) begin : g_rot
        localparam int I = j - 1;
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (y_reg[j-1][l] > 0) begin
                    x_next[j][l] = x_reg[j-1][l] + (y_reg[j-1][l] >>> I);
                    y_next[j][l] = y_reg[j-1][l] - (x_reg[j-1][l] >>> I);
                    a_next[j][l] = a_reg[j-1][l] + atan_tab(TAB_IDX_W'(I));
                end else if (y_reg[j-1][l] < 0) begin
                    x_next[j][l] = x_reg[j-1][l] - (y_reg[j-1][l] >>> I);
                    y_next[j][l] = y_reg[j-1][l] + (x_reg[j-1][l] >>> I);
                    a_next[j][l] = a_reg[j-1][l] - atan_tab(TAB_IDX_W'(I));
                end else begin
                    x_next[j][l] = x_reg[j-1][l];
                    y_next[j][l] = y_reg[j-1][l];
                    a_next[j][l] = a_reg[j-1][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) tag_reg[0] <= in_tag;
        for (int k = 1; k < NS; k++) begin
            if (en[k]) tag_reg[k] <= tag_reg[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                a_reg[k] <= a_next[k];
            end
        end
    end

endmodule

FILE: design/quaternion_to_euler.sv
// Quaternion to roll, pitch and yaw converter.
// Input beats arrive on s_axis_*: tdata carries quat_x, quat_y, quat_z and
// quat_w (signed Q1.15). Result beats leave on m_axis_*: tdata carries
// roll, pitch and yaw as signed binary angles (32768 = pi), tuser carries
// pitch_clamped, set when the pitch sine reached one in magnitude and pitch
// was pinned to plus or minus half pi.
// Every input beat gives exactly one result beat, in order.
// Throughput: one beat per cycle while m_axis_tready does not stall the
// pipeline. The pipeline is made of 4 product/sum stages, 31 square root
// stages (one root bit each), 1 + CORDIC_STEPS CORDIC stages run on three
// lanes side by side, and the output register.
// Each stage advances when it is empty or its successor advances, so
// s_axis_tready stays high while bubbles remain in the pipeline even when
// m_axis_tready is low; a full stalled pipeline holds every beat in place.
// aresetn (synchronous, active low) empties the pipeline; beats in flight
// are dropped.
module quaternion_to_euler
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] quat_x, [31:16] quat_y, [47:32] quat_z, [63:48] quat_w
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] roll_angle, [31:16] pitch_angle, [47:32] yaw_angle
    output logic [47:0]  m_axis_tdata,
    // [0] pitch_clamped
    output logic         m_axis_tuser
);

    logic              fr_valid, fr_ready;
    logic [REM_W-1:0]  fr_rest;
    q2e_side_t         fr_side;

    logic              sq_valid, sq_ready;
    logic [ROOT_W-1:0] sq_root;
    q2e_side_t         sq_side;

    logic                    cr_valid, cr_ready;
    logic signed [CRD_W-1:0] cr_x [LANES];
    logic signed [CRD_W-1:0] cr_y [LANES];
    q2e_tag_t                cr_tag_in, cr_tag;
    logic [ANG_W-1:0]        cr_angle [LANES];

    logic              out_valid_reg;
    logic [OUT_W-1:0]  roll_reg, pitch_reg, yaw_reg;
    logic              clamp_reg;
    logic [OUT_W-1:0]  roll_next, pitch_next, yaw_next;
    logic              out_en;

    q2e_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .quat_x    (s_axis_tdata[15:0]),
        .quat_y    (s_axis_tdata[31:16]),
        .quat_z    (s_axis_tdata[47:32]),
        .quat_w    (s_axis_tdata[63:48]),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_rest  (fr_rest),
        .out_side  (fr_side)
    );

    q2e_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_rest   (fr_rest),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Lane vectors: pitch is atan2(sine, sqrt(1 - sine^2))
    always_comb begin
        cr_x[LANE_ROLL]     = CRD_W'(sq_side.roll_c);
        cr_y[LANE_ROLL]     = CRD_W'(sq_side.roll_s);
        cr_x[LANE_PITCH]    = CRD_W'(sq_root);
        cr_y[LANE_PITCH]    = CRD_W'(sq_side.pitch_s);
        cr_x[LANE_YAW]      = CRD_W'(sq_side.yaw_c);
        cr_y[LANE_YAW]      = CRD_W'(sq_side.yaw_s);
        cr_tag_in.clamp     = sq_side.clamp;
        cr_tag_in.clamp_neg = sq_side.clamp_neg;
    end

    q2e_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_x      (cr_x),
        .in_y      (cr_y),
        .in_tag    (cr_tag_in),
        .out_valid (cr_valid),
        .out_ready (cr_ready),
        .out_angle (cr_angle),
        .out_tag   (cr_tag)
    );

    // Round angles to nearest, half up, wrapping at pi
    always_comb begin
        roll_next = cr_angle[LANE_ROLL][ANG_W-1:ANG_W-OUT_W]
                  + OUT_W'(cr_angle[LANE_ROLL][ANG_W-OUT_W-1]);
        yaw_next  = cr_angle[LANE_YAW][ANG_W-1:ANG_W-OUT_W]
                  + OUT_W'(cr_angle[LANE_YAW][ANG_W-OUT_W-1]);
        if (cr_tag.clamp) begin
            pitch_next = cr_tag.clamp_neg ? PITCH_NEG_CLAMP : PITCH_POS_CLAMP;
        end else begin
            pitch_next = cr_angle[LANE_PITCH][ANG_W-1:ANG_W-OUT_W]
                       + OUT_W'(cr_angle[LANE_PITCH][ANG_W-OUT_W-1]);
        end
    end

    // Output register: load when empty or the beat is taken
    assign out_en   = !out_valid_reg || m_axis_tready;
    assign cr_ready = out_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= cr_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            clamp_reg <= cr_tag.clamp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {yaw_reg, pitch_reg, roll_reg};
    assign m_axis_tuser  = clamp_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb
    import q2e_pkg::*;
;

    localparam int N_RANDOM    = 512;
    localparam int LATENCY     = 37 + CORDIC_STEPS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } euler_t;

    // Angle predictor and in-order store of expected angles
    class euler_scoreboard;
        euler_t pending[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        // floor shift right of a signed value
        static function longint sra(longint v, int s);
            return v >= 0 ? (v >>> s) : ~((~v) >>> s);
        endfunction

        // vectoring CORDIC: angle of (cx, sy), 2^32 a full circle
        static function logic [31:0] vector_angle(longint cx, longint sy);
            logic [31:0] ang;
            longint      dx, dy;
            ang = 32'h0;
            if (cx == 0 && sy == 0) return 32'h0;
            if (cx < 0) begin
                ang = ANG_PI;
                cx  = -cx;
                sy  = -sy;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
                dx = sra(sy, i);
                dy = sra(cx, i);
                if (sy > 0) begin
                    cx += dx; sy -= dy; ang += atan_tab(5'(i));
                end else if (sy < 0) begin
                    cx -= dx; sy += dy; ang -= atan_tab(5'(i));
                end
            end
            return ang;
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // round half up into 16 bits, wrapping
        static function logic [15:0] round_angle(logic [31:0] a);
            logic [31:0] t;
            t = a + 32'h8000;
            return t[31:16];
        endfunction

        function void note_quat(logic [63:0] beat);
            longint      qx, qy, qz, qw, sr, cr, sw, cw, sp;
            logic [31:0] pa;
            euler_t      e;
            qx = longint'($signed(beat[15:0]));
            qy = longint'($signed(beat[31:16]));
            qz = longint'($signed(beat[47:32]));
            qw = longint'($signed(beat[63:48]));
            sr = 2 * (qw * qx + qy * qz);
            cr = (64'sd1 << 30) - 2 * (qx * qx + qy * qy);
            sw = 2 * (qw * qz + qx * qy);
            cw = (64'sd1 << 30) - 2 * (qy * qy + qz * qz);
            sp = 2 * (qw * qy - qz * qx);
            e.clamped = 1'b0;
            if (sp >= (64'sd1 << 30)) begin
                pa = 32'h4000_0000; e.clamped = 1'b1;
            end else if (sp <= -(64'sd1 << 30)) begin
                pa = 32'hC000_0000; e.clamped = 1'b1;
            end else begin
                pa = vector_angle(longint'(int_sqrt((64'd1 << 60) - sp * sp)), sp);
            end
            e.roll  = round_angle(vector_angle(cr, sr));
            e.pitch = round_angle(pa);
            e.yaw   = round_angle(vector_angle(cw, sw));
            pending.push_back(e);
        endfunction

        function void check_angles(logic [47:0] data, logic user);
            euler_t e;
            if (pending.size() == 0) begin
                $error("unexpected result beat %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.roll) begin
                $error("roll_angle expected %0d got %0d", e.roll, $signed(data[15:0]));
                errors++;
            end
            if (data[31:16] !== e.pitch) begin
                $error("pitch_angle expected %0d got %0d", e.pitch, $signed(data[31:16]));
                errors++;
            end
            if (data[47:32] !== e.yaw) begin
                $error("yaw_angle expected %0d got %0d", e.yaw, $signed(data[47:32]));
                errors++;
            end
            if (user !== e.clamped) begin
                $error("pitch_clamped expected %0d got %0d", e.clamped, user);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    int  idle_pct;
    int  stall_pct;
    bit  hold_off;
    int  cycles;
    euler_scoreboard angles;

    quaternion_to_euler u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Check every accepted result beat; watch for a hang
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready)
            angles.check_angles(m_axis_tdata, m_axis_tuser);
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one quaternion beat, with an optional idle gap first
    task automatic send_quat(logic [63:0] beat);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        angles.note_quat(beat);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (angles.pending.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    // Near unit quaternion: mostly well-formed orientations
    function automatic logic [63:0] unit_quat();
        real a, b, c, d, n;
        a = real'(int'($urandom_range(2000)) - 1000);
        b = real'(int'($urandom_range(2000)) - 1000);
        c = real'(int'($urandom_range(2000)) - 1000);
        d = real'(int'($urandom_range(2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        return {16'($rtoi(d / n * 32767.0)), 16'($rtoi(c / n * 32767.0)),
                16'($rtoi(b / n * 32767.0)), 16'($rtoi(a / n * 32767.0))};
    endfunction

    function automatic logic [63:0] random_quat();
        int k;
        k = $urandom_range(99);
        if (k < 60) return unit_quat();
        if (k < 80) return {pick_comp(), pick_comp(), pick_comp(), pick_comp()};
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] directed[$];
        angles        = new();
        cycles        = 0;
        hold_off      = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, zero vector, identity, gimbal lock both ways,
        // negative cosines, pi angles
        directed = '{64'h0, {16'h7FFF, 48'h0}, {16'h8000, 48'h0},
                     64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
                     {16'h5A82, 16'h0, 16'h5A82, 16'h0},
                     {16'h5A82, 16'h0, 16'hA57E, 16'h0},
                     {16'h4000, 16'h0, 16'h4000, 16'h0},
                     {48'h0, 16'h7FFF}, {32'h0, 16'h7FFF, 16'h0},
                     {16'h0, 16'h7FFF, 32'h0}, {48'h0, 16'h8000},
                     64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
                     64'h0001_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555,
                     {16'h0, 16'h5A82, 16'h0, 16'h5A82}};
        foreach (directed[i]) send_quat(directed[i]);
        drain();

        // Random phases over idle/stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 18 : 71) : 0;
            stall_pct = (ph == 2) ? 71 : ((ph == 3) ? 18 : 0);
            for (int n = 0; n < N_RANDOM / 4; n++) send_quat(random_quat());
            if (ph == 1) drain();
        end

        // Long receiver hold-off while the sender keeps offering beats
        idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                @(negedge aclk);
                hold_off = 1'b1;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 120; n++) send_quat(random_quat());
        join

        drain();
        repeat (LATENCY + 10) @(negedge aclk);
        if (angles.errors == 0 && angles.pending.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
